// ----- hdl/rrts_pkg.sv -----
`timescale 1ns / 1ps

package rrts_pkg;

  // Thread slots and widths
  localparam int THREADS   = 8;
  localparam int SLOT_W    = $clog2(THREADS);
  localparam int SUM_W     = SLOT_W + 1;
  localparam int ID_W      = 3;

  // Fresh stack frame: 28 saved registers below the stack top
  localparam int REG_BYTES = 4;
  localparam int CTX_WORDS = 28;
  localparam logic [31:0] CTX_BYTES = 32'(REG_BYTES * CTX_WORDS);

  // Reset values of the configuration registers
  localparam logic [31:0] STACK_TOP_RST    = 32'd0;
  localparam logic [20:0] STACK_SIZE_RST   = 21'd4096;
  localparam logic [31:0] THREAD_ENTRY_RST = 32'd0;
  localparam logic [31:0] TIMESLICE_RST    = 32'd100000;

  // Beat widths
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 168;
  localparam int CFG_IDX_W  = 2;
  localparam int CTX_W      = 64;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_SWITCH = 2'd1,
    OP_YIELD  = 2'd2,
    OP_EXIT   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STACK_TOP    = 2'd0,
    CFG_STACK_SIZE   = 2'd1,
    CFG_THREAD_ENTRY = 2'd2,
    CFG_TIMESLICE    = 2'd3
  } cfg_idx_e;

  // Slot search results
  typedef struct packed {
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic              next_found;
    logic [SLOT_W-1:0] next_slot;
  } pick_t;

endpackage

// ----- hdl/rrts_ram.sv -----
`timescale 1ns / 1ps

module rrts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/rrts_pick.sv -----
`timescale 1ns / 1ps

module rrts_pick (
  input  logic [rrts_pkg::THREADS-1:0] occ_i,
  input  logic [rrts_pkg::SLOT_W-1:0]  cur_i,
  output rrts_pkg::pick_t              pick_o
);
  import rrts_pkg::*;

  // Lowest free slot, and the next occupied slot after the current one
  always_comb begin
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] idx;
    pick_o = '0;
    for (int s = THREADS - 1; s >= 0; s--) begin
      if (!occ_i[s]) begin
        pick_o.free_found = 1'b1;
        pick_o.free_slot  = SLOT_W'(s);
      end
    end
    // descending distance, so the nearest occupied slot wins
    for (int k = THREADS; k >= 1; k--) begin
      sum = {1'b0, cur_i} + SUM_W'(k);
      idx = (sum >= SUM_W'(THREADS)) ? sum - SUM_W'(THREADS) : sum;
      if (occ_i[idx[SLOT_W-1:0]]) begin
        pick_o.next_found = 1'b1;
        pick_o.next_slot  = idx[SLOT_W-1:0];
      end
    end
  end

endmodule

// ----- hdl/round_robin_thread_scheduler.sv -----
`timescale 1ns / 1ps
// An input beat is registered into the pending result and the slot table reads;
// its result beat is then loaded into the output register.
// A new input beat is taken only once the pending result has moved into the
// output register. A stalled output holds the next item.
// Reset: no slot occupied, current thread is the last slot, registers at their
// defaults. The slot tables are not cleared; only created slots are ever read.
module round_robin_thread_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input beats
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // entry_function, saved_sp, saved_pc, now_time
  input  logic [rrts_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // op
  input  logic [1:0]                     s_axis_tuser,
  // result beats
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // thread_id, new_sp, new_pc, target_function, next_compare, zero pad
  output logic [rrts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [1:0]                     m_axis_tuser,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rrts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import rrts_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DONE
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [31:0] stack_top_q, thread_entry_q, timeslice_q;
  logic [20:0] stack_size_q;

  // Scheduler state
  logic [THREADS-1:0] occ_q, occ_d;
  logic [SLOT_W-1:0]  cur_q, cur_d;

  // Pending result
  status_e     res_status_q, res_status_d;
  logic [ID_W-1:0] res_id_q, res_id_d;
  logic [31:0] res_sp_q, res_pc_q, res_fn_q;
  logic [31:0] res_sp_d, res_pc_d, res_fn_d;
  logic [63:0] res_cmp_q, res_cmp_d;
  logic        use_ram_q, fwd_q;
  logic        use_ram_d, fwd_d;

  // Output register
  logic        m_valid_q;
  status_e     out_status_q;
  logic [ID_W-1:0] out_id_q;
  logic [31:0] out_sp_q, out_pc_q, out_fn_q;
  logic [63:0] out_cmp_q;

  logic        accept, out_take, out_load;
  op_e         in_op;
  logic [31:0] in_fn, in_sp, in_pc;
  logic [63:0] in_now;
  pick_t       pick;
  logic [31:0] create_sp;
  logic [63:0] switch_cmp;
  logic [THREADS-1:0] exit_map;

  logic              ctx_we, ctx_re, fn_we;
  logic [SLOT_W-1:0] ctx_waddr;
  logic [CTX_W-1:0]  ctx_wdata, ctx_rdata;
  logic [31:0]       fn_rdata;
  logic [31:0]       fin_sp, fin_pc, fin_fn;

  // Handshakes
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_take      = m_valid_q && m_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  // Input beat fields
  assign in_op  = op_e'(s_axis_tuser);
  assign in_fn  = s_axis_tdata[31:0];
  assign in_sp  = s_axis_tdata[63:32];
  assign in_pc  = s_axis_tdata[95:64];
  assign in_now = s_axis_tdata[159:96];

  rrts_pick u_pick (
    .occ_i  (occ_q),
    .cur_i  (cur_q),
    .pick_o (pick)
  );

  // Fresh stack pointer and next timer compare
  assign create_sp  = stack_top_q - (32'(stack_size_q) * 32'(pick.free_slot)) - CTX_BYTES;
  assign switch_cmp = in_now + {32'd0, timeslice_q};
  assign exit_map   = occ_q & ~(THREADS'(1) << cur_q);

  // Slot table writes and reads, all at the accept edge
  assign ctx_we    = accept && (((in_op == OP_CREATE) && pick.free_found) ||
                                (in_op == OP_SWITCH));
  assign ctx_waddr = (in_op == OP_CREATE) ? pick.free_slot : cur_q;
  assign ctx_wdata = (in_op == OP_CREATE) ? {thread_entry_q, create_sp} : {in_pc, in_sp};
  assign ctx_re    = accept && (in_op == OP_SWITCH);
  assign fn_we     = accept && (in_op == OP_CREATE) && pick.free_found;

  // sp in the low half, pc in the high half
  rrts_ram #(
    .WIDTH (CTX_W),
    .DEPTH (THREADS)
  ) u_ctx_ram (
    .clk_i   (clk_i),
    .we_i    (ctx_we),
    .waddr_i (ctx_waddr),
    .wdata_i (ctx_wdata),
    .re_i    (ctx_re),
    .raddr_i (pick.next_slot),
    .rdata_o (ctx_rdata)
  );

  rrts_ram #(
    .WIDTH (32),
    .DEPTH (THREADS)
  ) u_fn_ram (
    .clk_i   (clk_i),
    .we_i    (fn_we),
    .waddr_i (pick.free_slot),
    .wdata_i (in_fn),
    .re_i    (ctx_re),
    .raddr_i (pick.next_slot),
    .rdata_o (fn_rdata)
  );

  // Scheduler update and result for the beat being taken
  always_comb begin
    occ_d        = occ_q;
    cur_d        = cur_q;
    res_status_d = ST_OK;
    res_id_d     = ID_W'(cur_q);
    res_sp_d     = '0;
    res_pc_d     = '0;
    res_fn_d     = '0;
    res_cmp_d    = '0;
    use_ram_d    = 1'b0;
    fwd_d        = 1'b0;
    case (in_op)
      OP_CREATE: begin
        if (pick.free_found) begin
          occ_d[pick.free_slot] = 1'b1;
          res_id_d = ID_W'(pick.free_slot);
          res_sp_d = create_sp;
          res_pc_d = thread_entry_q;
          res_fn_d = in_fn;
        end else begin
          res_status_d = ST_FULL;
          res_id_d     = '0;
        end
      end
      OP_SWITCH: begin
        res_cmp_d = switch_cmp;
        if (pick.next_found) begin
          cur_d     = pick.next_slot;
          res_id_d  = ID_W'(pick.next_slot);
          res_sp_d  = in_sp;
          res_pc_d  = in_pc;
          use_ram_d = 1'b1;
          fwd_d     = (pick.next_slot == cur_q);
        end else begin
          res_status_d = ST_NONE;
        end
      end
      OP_YIELD: ;
      OP_EXIT: begin
        occ_d = exit_map;
        if (exit_map == '0) begin
          res_status_d = ST_NONE;
        end
      end
      default: ;
    endcase
  end

  // Final fields; the slot just saved is forwarded when it is picked again
  always_comb begin
    fin_sp = res_sp_q;
    fin_pc = res_pc_q;
    fin_fn = res_fn_q;
    if (use_ram_q) begin
      fin_fn = fn_rdata;
      if (!fwd_q) begin
        fin_sp = ctx_rdata[31:0];
        fin_pc = ctx_rdata[63:32];
      end
    end
  end

  // Control state, configuration and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      stack_top_q    <= STACK_TOP_RST;
      stack_size_q   <= STACK_SIZE_RST;
      thread_entry_q <= THREAD_ENTRY_RST;
      timeslice_q    <= TIMESLICE_RST;
      occ_q          <= '0;
      cur_q          <= SLOT_W'(THREADS - 1);
      res_status_q   <= ST_OK;
      res_id_q       <= '0;
      res_sp_q       <= '0;
      res_pc_q       <= '0;
      res_fn_q       <= '0;
      res_cmp_q      <= '0;
      use_ram_q      <= 1'b0;
      fwd_q          <= 1'b0;
      m_valid_q      <= 1'b0;
      out_status_q   <= ST_OK;
      out_id_q       <= '0;
      out_sp_q       <= '0;
      out_pc_q       <= '0;
      out_fn_q       <= '0;
      out_cmp_q      <= '0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_STACK_TOP:    stack_top_q    <= cfg_data_i;
          CFG_STACK_SIZE:   stack_size_q   <= cfg_data_i[20:0];
          CFG_THREAD_ENTRY: thread_entry_q <= cfg_data_i;
          CFG_TIMESLICE:    timeslice_q    <= cfg_data_i;
          default: ;
        endcase
      end

      // output valid: a new load wins over a take in the same cycle
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (out_take) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q      <= S_DONE;
            occ_q        <= occ_d;
            cur_q        <= cur_d;
            res_status_q <= res_status_d;
            res_id_q     <= res_id_d;
            res_sp_q     <= res_sp_d;
            res_pc_q     <= res_pc_d;
            res_fn_q     <= res_fn_d;
            res_cmp_q    <= res_cmp_d;
            use_ram_q    <= use_ram_d;
            fwd_q        <= fwd_d;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_q      <= S_IDLE;
            out_status_q <= res_status_q;
            out_id_q     <= res_id_q;
            out_sp_q     <= fin_sp;
            out_pc_q     <= fin_pc;
            out_fn_q     <= fin_fn;
            out_cmp_q    <= res_cmp_q;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result beat
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {5'd0, out_cmp_q, out_fn_q, out_pc_q, out_sp_q, out_id_q};

  // Exit frees the slot that was running
  a_exit_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_op == OP_EXIT) |=> !occ_q[$past(cur_q)])
    else $error("exit left the current slot occupied");

  // A successful switch lands on an occupied slot
  a_switch_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_op == OP_SWITCH) && pick.next_found |=> occ_q[cur_q])
    else $error("switch selected a free slot");

  // Create on a full map reports no free slot
  a_create_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_op == OP_CREATE) && (occ_q == '1) |=> res_status_q == ST_FULL)
    else $error("create on full map not reported");

endmodule
